[hdl/wruv_pkg.sv]
// wruv_pkg: shared widths, item/result structs and codes for the water refraction uv offset block
// no dependencies; imported by water_refraction_uv_offset and the testbench
`default_nettype none
package wruv_pkg;

  localparam int UV_FRACTION_BITS = 16;
  localparam int DEPTH_BITS       = 32;
  localparam int UV_W             = UV_FRACTION_BITS + 1;
  localparam int NORM_BITS        = 16;
  localparam int PROD_W           = 32;
  localparam int PT_W             = PROD_W + NORM_BITS + 1;
  localparam int OFF_SHIFT        = 14 + 12 + NORM_BITS - UV_FRACTION_BITS;
  localparam int MAG_W            = UV_FRACTION_BITS + 5;
  localparam int SQ_W             = 2 * MAG_W;
  localparam int LEN_W            = MAG_W + 1;
  localparam int LIM_W            = 32;
  localparam int MAX_W            = 16;
  localparam int EXT_W            = (DEPTH_BITS > LIM_W) ? DEPTH_BITS + 2 : LIM_W + 2;
  localparam int CMP_W            = (SQ_W > 2 * MAX_W) ? SQ_W : 2 * MAX_W;
  localparam int QEXT_W           = (MAG_W > MAX_W) ? MAG_W : MAX_W;
  localparam int CAND_W           = MAG_W + 2;
  localparam int MARGIN_W         = 15;
  localparam int MARGIN_CAP       = (1 << UV_FRACTION_BITS) * 499 / 1000;
  localparam int UV_ONE           = 1 << UV_FRACTION_BITS;
  localparam int CFG_W            = 32;
  localparam int CFG_IDX_W        = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STRENGTH,
    REG_MAX_OFFSET,
    REG_BIAS,
    REG_LIMIT,
    REG_MARGIN
  } cfg_reg_t;

  typedef enum logic [1:0] {
    FB_NONE,
    FB_ZERO,
    FB_OFFSCREEN,
    FB_FOREGROUND
  } fb_code_t;

  typedef struct packed {
    logic [UV_W-1:0]       pixel_u;
    logic [UV_W-1:0]       pixel_v;
    logic signed [15:0]    normal_x;
    logic signed [15:0]    normal_y;
    logic [DEPTH_BITS-1:0] surface_depth;
    logic [DEPTH_BITS-1:0] scene_depth;
    logic [DEPTH_BITS-1:0] shifted_scene_depth;
  } item_t;

  typedef struct packed {
    logic [UV_W-1:0]       out_u;
    logic [UV_W-1:0]       out_v;
    logic [DEPTH_BITS-1:0] water_thickness;
    logic [1:0]            fallback_code;
  } result_t;

  // per-pixel facts settled early and carried down the pipe
  typedef struct packed {
    logic [UV_W-1:0]       pixel_u;
    logic [UV_W-1:0]       pixel_v;
    logic [UV_W-1:0]       fb_u;
    logic [UV_W-1:0]       fb_v;
    logic [DEPTH_BITS-1:0] thick;
    logic                  zero;
    logic                  fg;
  } keep_t;

  typedef struct packed {
    keep_t                  keep;
    logic signed [PROD_W-1:0] px;
    logic signed [PROD_W-1:0] py;
    logic                   full;
  } norm_side_t;

  typedef struct packed {
    keep_t            keep;
    logic             sx;
    logic             sy;
    logic [MAG_W-1:0] mx;
    logic [MAG_W-1:0] my;
    logic             shrink;
  } sqrt_side_t;

  typedef struct packed {
    keep_t            keep;
    logic             sx;
    logic [MAG_W-1:0] mx;
    logic             shrink;
  } divx_side_t;

  typedef struct packed {
    logic             sy;
    logic [MAG_W-1:0] my;
  } divy_side_t;

endpackage
`default_nettype wire

[hdl/wruv_div.sv]
// wruv_div: pipelined restoring divider, one quotient bit per stage, side data alongside
// depends on nothing but the clock; used by water_refraction_uv_offset
`default_nettype none
module wruv_div #(
  parameter int DEN_W  = 32,
  parameter int Q_W    = 16,
  parameter int SIDE_W = 1
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire logic [DEN_W-1:0]  in_hi,
  input  wire logic [Q_W-1:0]    in_lo,
  input  wire logic [DEN_W-1:0]  in_den,
  input  wire logic [SIDE_W-1:0] in_side,
  output logic                   out_valid,
  output logic [Q_W-1:0]         out_quo,
  output logic [SIDE_W-1:0]      out_side
);

  logic              vld  [0:Q_W];
  logic [DEN_W-1:0]  rem  [0:Q_W];
  logic [DEN_W-1:0]  den  [0:Q_W];
  logic [Q_W-1:0]    lo   [0:Q_W];
  logic [Q_W-1:0]    quo  [0:Q_W];
  logic [SIDE_W-1:0] side [0:Q_W];

  // in_hi must be below in_den
  assign vld[0]  = in_valid;
  assign rem[0]  = in_hi;
  assign den[0]  = in_den;
  assign lo[0]   = in_lo;
  assign quo[0]  = '0;
  assign side[0] = in_side;

  for (genvar i = 0; i < Q_W; i++) begin : g_step
    logic [DEN_W:0] trial;
    logic [DEN_W:0] diff;
    logic           ge;

    assign trial = {rem[i], lo[i][Q_W-1]};
    assign diff  = trial - {1'b0, den[i]};
    assign ge    = trial >= {1'b0, den[i]};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else begin
        vld[i+1] <= vld[i];
      end
      rem[i+1]  <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      den[i+1]  <= den[i];
      lo[i+1]   <= {lo[i][Q_W-2:0], 1'b0};
      quo[i+1]  <= {quo[i][Q_W-2:0], ge};
      side[i+1] <= side[i];
    end
  end

  assign out_valid = vld[Q_W];
  assign out_quo   = quo[Q_W];
  assign out_side  = side[Q_W];

endmodule
`default_nettype wire

[hdl/wruv_sqrt.sv]
// wruv_sqrt: pipelined square root rounded up, one root bit per stage, side data alongside
// depends on nothing but the clock; used by water_refraction_uv_offset
`default_nettype none
module wruv_sqrt #(
  parameter int S_W    = 42,
  parameter int SIDE_W = 1
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire logic [S_W-1:0]    in_rad,
  input  wire logic [SIDE_W-1:0] in_side,
  output logic                   out_valid,
  output logic [S_W/2:0]         out_root,
  output logic [SIDE_W-1:0]      out_side
);

  localparam int R_W = S_W / 2;

  logic              vld  [0:R_W];
  logic [R_W:0]      rem  [0:R_W];
  logic [R_W-1:0]    root [0:R_W];
  logic [S_W-1:0]    rad  [0:R_W];
  logic [SIDE_W-1:0] side [0:R_W];

  assign vld[0]  = in_valid;
  assign rem[0]  = '0;
  assign root[0] = '0;
  assign rad[0]  = in_rad;
  assign side[0] = in_side;

  for (genvar i = 0; i < R_W; i++) begin : g_step
    logic [R_W+2:0] cur;
    logic [R_W+2:0] trial;
    logic [R_W+2:0] diff;
    logic           ge;

    assign cur   = {rem[i], rad[i][S_W-1:S_W-2]};
    assign trial = {1'b0, root[i], 2'b01};
    assign diff  = cur - trial;
    assign ge    = cur >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else begin
        vld[i+1] <= vld[i];
      end
      rem[i+1]  <= ge ? diff[R_W:0] : cur[R_W:0];
      root[i+1] <= {root[i][R_W-2:0], ge};
      rad[i+1]  <= {rad[i][S_W-3:0], 2'b00};
      side[i+1] <= side[i];
    end
  end

  // a nonzero remainder means the floor root squared falls short, so round up
  assign out_valid = vld[R_W];
  assign out_root  = {1'b0, root[R_W]} + {{R_W{1'b0}}, (rem[R_W] != '0)};
  assign out_side  = side[R_W];

endmodule
`default_nettype wire

[hdl/water_refraction_uv_offset.sv]
// water_refraction_uv_offset: top level, config registers and the per-pixel pipeline
// depends on wruv_pkg, wruv_div and wruv_sqrt
//
// Usage
//   One pixel beat is taken at each rising edge where start is high and busy is low.
//   busy is high only during reset and the cycle after it; otherwise a pixel may be
//   offered in every cycle, so the rate is one pixel per clock.
//   Each pixel gives exactly one result, shown on result for a single cycle with done
//   high, in the order the pixels came in. The receiver cannot stall, and nothing
//   inside ever waits: every stage advances on every clock.
//   done rises through 61 register stages after the accepting edge: two
//   input stages, a 16-stage normalising divider, four multiply/round/square stages,
//   a 21-stage square root for the offset length, one scaling multiply, two parallel
//   16-stage shortening dividers (one per axis) and the output register.
//   Configuration writes come on cfg_valid/cfg_index/cfg_data; cfg_ready is always
//   high. The user must write registers only while no pixel is in flight; the block does not enforce it.
//   Reset (rst, synchronous) empties the pipeline and loads the register defaults.
`default_nettype none
module water_refraction_uv_offset
  import wruv_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  output logic                      busy,
  input  wire item_t                item,
  output logic                      done,
  output result_t                   result,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data
);

  localparam int NS_W = $bits(norm_side_t);
  localparam int SS_W = $bits(sqrt_side_t);
  localparam int XS_W = $bits(divx_side_t);
  localparam int YS_W = $bits(divy_side_t);

  // configuration registers
  logic signed [15:0]      strength;
  logic [MAX_W-1:0]        max_off;
  logic [LIM_W-1:0]        bias;
  logic [LIM_W-1:0]        limit;
  logic [MARGIN_W-1:0]     margin;
  logic [2*MAX_W-1:0]      max_sq;
  logic [LIM_W-1:0]        lim_eff;

  assign cfg_ready = 1'b1;
  assign lim_eff   = (limit == '0) ? LIM_W'(1) : limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      strength <= 16'sd4096;
      max_off  <= MAX_W'(2048);
      bias     <= '0;
      limit    <= LIM_W'(65536);
      margin   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_STRENGTH:   strength <= $signed(cfg_data[15:0]);
        REG_MAX_OFFSET: max_off  <= cfg_data[MAX_W-1:0];
        REG_BIAS:       bias     <= cfg_data[LIM_W-1:0];
        REG_LIMIT:      limit    <= cfg_data[LIM_W-1:0];
        REG_MARGIN:     margin   <= cfg_data[MARGIN_W-1:0];
        default: ;
      endcase
    end
    max_sq <= max_off * max_off;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
    end else begin
      busy <= 1'b0;
    end
  end

  // stage a: input register
  logic  accept;
  logic  a_vld;
  item_t a_item;

  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else begin
      a_vld <= accept;
    end
    a_item <= item;
  end

  // stage b: thickness, flags, normal times strength
  logic signed [EXT_W-1:0] thick_x;
  logic signed [EXT_W-1:0] bias_x;
  logic signed [EXT_W-1:0] lim_x;
  logic signed [EXT_W-1:0] d_x;
  keep_t                   keep_b;
  logic                    full_b;
  logic                    b_vld;
  norm_side_t              b_side;
  logic [LIM_W-1:0]        b_hi;

  assign thick_x = $signed(EXT_W'(a_item.scene_depth)) - $signed(EXT_W'(a_item.surface_depth));
  assign bias_x  = $signed(EXT_W'(bias));
  assign lim_x   = $signed(EXT_W'(lim_eff));
  assign d_x     = thick_x - bias_x;
  assign full_b  = d_x >= lim_x;

  always_comb begin
    keep_b.pixel_u = a_item.pixel_u;
    keep_b.pixel_v = a_item.pixel_v;
    keep_b.fb_u    = (a_item.pixel_u > UV_W'(UV_ONE)) ? UV_W'(UV_ONE) : a_item.pixel_u;
    keep_b.fb_v    = (a_item.pixel_v > UV_W'(UV_ONE)) ? UV_W'(UV_ONE) : a_item.pixel_v;
    keep_b.zero    = thick_x <= bias_x;
    keep_b.fg      = EXT_W'(a_item.shifted_scene_depth)
                     <= EXT_W'(a_item.surface_depth) + EXT_W'(bias);
    if (thick_x[EXT_W-1] || thick_x == '0) begin
      keep_b.thick = '0;
    end else if (thick_x > lim_x) begin
      keep_b.thick = lim_x[DEPTH_BITS-1:0];
    end else begin
      keep_b.thick = thick_x[DEPTH_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_vld <= 1'b0;
    end else begin
      b_vld <= a_vld;
    end
    b_side.keep <= keep_b;
    b_side.px   <= a_item.normal_x * strength;
    b_side.py   <= a_item.normal_y * strength;
    b_side.full <= full_b;
    // divider wants its high part below the limit
    b_hi        <= (full_b || keep_b.zero) ? '0 : d_x[LIM_W-1:0];
  end

  // normalised thickness divider
  logic             n_vld;
  logic [NORM_BITS-1:0] n_quo;
  logic [NS_W-1:0]  n_side_raw;
  norm_side_t       n_side;

  wruv_div #(.DEN_W(LIM_W), .Q_W(NORM_BITS), .SIDE_W(NS_W)) u_norm_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (b_vld),
    .in_hi     (b_hi),
    .in_lo     ('0),
    .in_den    (lim_eff),
    .in_side   (b_side),
    .out_valid (n_vld),
    .out_quo   (n_quo),
    .out_side  (n_side_raw)
  );

  assign n_side = n_side_raw;

  // stage c: times normalised thickness
  logic [NORM_BITS:0]      t_c;
  logic                    c_vld;
  keep_t                   c_keep;
  logic signed [PT_W-1:0]  c_px;
  logic signed [PT_W-1:0]  c_py;

  assign t_c = n_side.full ? (NORM_BITS+1)'(1 << NORM_BITS) : {1'b0, n_quo};

  always_ff @(posedge clk) begin
    if (rst) begin
      c_vld <= 1'b0;
    end else begin
      c_vld <= n_vld;
    end
    c_keep <= n_side.keep;
    c_px   <= n_side.px * $signed({1'b0, t_c});
    c_py   <= n_side.py * $signed({1'b0, t_c});
  end

  // stage d: magnitude rounded half away from zero
  logic [PT_W-1:0]  abs_x;
  logic [PT_W-1:0]  abs_y;
  logic [PT_W-1:0]  rnd_x;
  logic [PT_W-1:0]  rnd_y;
  logic             d_vld;
  keep_t            d_keep;
  logic             d_sx;
  logic             d_sy;
  logic [MAG_W-1:0] d_mx;
  logic [MAG_W-1:0] d_my;

  assign abs_x = c_px[PT_W-1] ? PT_W'(-c_px) : PT_W'(c_px);
  assign abs_y = c_py[PT_W-1] ? PT_W'(-c_py) : PT_W'(c_py);
  assign rnd_x = (abs_x + (PT_W'(1) << (OFF_SHIFT - 1))) >> OFF_SHIFT;
  assign rnd_y = (abs_y + (PT_W'(1) << (OFF_SHIFT - 1))) >> OFF_SHIFT;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_vld <= 1'b0;
    end else begin
      d_vld <= c_vld;
    end
    d_keep <= c_keep;
    d_sx   <= c_px[PT_W-1];
    d_sy   <= c_py[PT_W-1];
    d_mx   <= rnd_x[MAG_W-1:0];
    d_my   <= rnd_y[MAG_W-1:0];
  end

  // stage e: squares
  logic            e_vld;
  sqrt_side_t      e_side;
  logic [SQ_W-1:0] e_sqx;
  logic [SQ_W-1:0] e_sqy;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_vld <= 1'b0;
    end else begin
      e_vld <= d_vld;
    end
    e_side.keep   <= d_keep;
    e_side.sx     <= d_sx;
    e_side.sy     <= d_sy;
    e_side.mx     <= d_mx;
    e_side.my     <= d_my;
    e_side.shrink <= 1'b0;
    e_sqx         <= d_mx * d_mx;
    e_sqy         <= d_my * d_my;
  end

  // stage f: length squared against the maximum offset squared
  logic [SQ_W-1:0] sq_e;
  logic            f_vld;
  sqrt_side_t      f_side;
  logic [SQ_W-1:0] f_sq;

  assign sq_e = e_sqx + e_sqy;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_vld <= 1'b0;
    end else begin
      f_vld <= e_vld;
    end
    f_side.keep   <= e_side.keep;
    f_side.sx     <= e_side.sx;
    f_side.sy     <= e_side.sy;
    f_side.mx     <= e_side.mx;
    f_side.my     <= e_side.my;
    f_side.shrink <= CMP_W'(sq_e) > CMP_W'(max_sq);
    f_sq          <= sq_e;
  end

  // offset length
  logic            s_vld;
  logic [LEN_W-1:0] s_len;
  logic [SS_W-1:0] s_side_raw;
  sqrt_side_t      s_side;

  wruv_sqrt #(.S_W(SQ_W), .SIDE_W(SS_W)) u_len_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_vld),
    .in_rad    (f_sq),
    .in_side   (f_side),
    .out_valid (s_vld),
    .out_root  (s_len),
    .out_side  (s_side_raw)
  );

  assign s_side = s_side_raw;

  // stage g: magnitude times maximum length
  logic                   g_vld;
  logic [LEN_W-1:0]       g_len;
  logic [MAG_W+MAX_W-1:0] g_nx;
  logic [MAG_W+MAX_W-1:0] g_ny;
  divx_side_t             g_xside;
  divy_side_t             g_yside;

  always_ff @(posedge clk) begin
    if (rst) begin
      g_vld <= 1'b0;
    end else begin
      g_vld <= s_vld;
    end
    g_len          <= s_len;
    g_nx           <= s_side.mx * max_off;
    g_ny           <= s_side.my * max_off;
    g_xside.keep   <= s_side.keep;
    g_xside.sx     <= s_side.sx;
    g_xside.mx     <= s_side.mx;
    g_xside.shrink <= s_side.shrink;
    g_yside.sy     <= s_side.sy;
    g_yside.my     <= s_side.my;
  end

  // shortening dividers, magnitude never exceeds the length so the quotient fits
  logic             x_vld;
  logic             y_vld;
  logic [MAX_W-1:0] x_quo;
  logic [MAX_W-1:0] y_quo;
  logic [XS_W-1:0]  x_side_raw;
  logic [YS_W-1:0]  y_side_raw;
  divx_side_t       x_side;
  divy_side_t       y_side;

  wruv_div #(.DEN_W(LEN_W), .Q_W(MAX_W), .SIDE_W(XS_W)) u_shrink_x (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (g_vld),
    .in_hi     (LEN_W'(g_nx[MAG_W+MAX_W-1:MAX_W])),
    .in_lo     (g_nx[MAX_W-1:0]),
    .in_den    (g_len),
    .in_side   (g_xside),
    .out_valid (x_vld),
    .out_quo   (x_quo),
    .out_side  (x_side_raw)
  );

  wruv_div #(.DEN_W(LEN_W), .Q_W(MAX_W), .SIDE_W(YS_W)) u_shrink_y (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (g_vld),
    .in_hi     (LEN_W'(g_ny[MAG_W+MAX_W-1:MAX_W])),
    .in_lo     (g_ny[MAX_W-1:0]),
    .in_den    (g_len),
    .in_side   (g_yside),
    .out_valid (y_vld),
    .out_quo   (y_quo),
    .out_side  (y_side_raw)
  );

  assign x_side = x_side_raw;
  assign y_side = y_side_raw;

  // stage h: candidate, screen check, result
  logic [QEXT_W-1:0]        qx_e;
  logic [QEXT_W-1:0]        qy_e;
  logic [MAG_W-1:0]         ax;
  logic [MAG_W-1:0]         ay;
  logic signed [CAND_W-1:0] ox;
  logic signed [CAND_W-1:0] oy;
  logic signed [CAND_W-1:0] cu;
  logic signed [CAND_W-1:0] cv;
  logic signed [CAND_W-1:0] m_c;
  logic signed [CAND_W-1:0] hi_c;
  logic                     off;
  keep_t                    h_keep;
  result_t                  res_next;

  assign h_keep = x_side.keep;
  assign qx_e   = QEXT_W'(x_quo);
  assign qy_e   = QEXT_W'(y_quo);
  assign ax     = x_side.shrink ? qx_e[MAG_W-1:0] : x_side.mx;
  assign ay     = x_side.shrink ? qy_e[MAG_W-1:0] : y_side.my;
  assign ox     = x_side.sx ? -$signed({2'b00, ax}) : $signed({2'b00, ax});
  assign oy     = y_side.sy ? -$signed({2'b00, ay}) : $signed({2'b00, ay});
  assign cu     = $signed(CAND_W'(h_keep.pixel_u)) + ox;
  assign cv     = $signed(CAND_W'(h_keep.pixel_v)) + oy;
  assign m_c    = (CAND_W'(margin) > CAND_W'(MARGIN_CAP)) ? $signed(CAND_W'(MARGIN_CAP))
                                                          : $signed(CAND_W'(margin));
  assign hi_c   = $signed(CAND_W'(UV_ONE)) - m_c;
  assign off    = (cu < m_c) || (cu > hi_c) || (cv < m_c) || (cv > hi_c);

  always_comb begin
    res_next.out_u           = h_keep.fb_u;
    res_next.out_v           = h_keep.fb_v;
    res_next.water_thickness = h_keep.thick;
    if (h_keep.zero) begin
      res_next.fallback_code = FB_ZERO;
    end else if (off) begin
      res_next.fallback_code = FB_OFFSCREEN;
    end else if (h_keep.fg) begin
      res_next.fallback_code = FB_FOREGROUND;
    end else begin
      res_next.fallback_code = FB_NONE;
      res_next.out_u         = cu[UV_W-1:0];
      res_next.out_v         = cv[UV_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= x_vld && y_vld;
    end
    result <= res_next;
  end

  // both shortening dividers run in lock step
  a_div_lockstep: assert property (@(posedge clk) disable iff (rst) x_vld == y_vld)
    else $error("shortening dividers out of step");

  // shortening only happens when the rounded-up length exceeds the maximum
  a_shrink_len: assert property (@(posedge clk) disable iff (rst)
    g_vld && g_xside.shrink |-> LEN_W'(max_off) < g_len)
    else $error("shrink taken with length within the maximum");

  a_uv_range: assert property (@(posedge clk) disable iff (rst)
    done |-> result.out_u <= UV_W'(UV_ONE) && result.out_v <= UV_W'(UV_ONE))
    else $error("result uv beyond one");

  a_zero_thick: assert property (@(posedge clk) disable iff (rst)
    done && result.fallback_code == FB_ZERO |-> EXT_W'(result.water_thickness) <= EXT_W'(bias))
    else $error("zero thickness fallback with thickness above bias");

  a_thick_nonzero: assert property (@(posedge clk) disable iff (rst)
    done && result.fallback_code != FB_ZERO |-> result.water_thickness != '0)
    else $error("offset path with no thickness");

endmodule
`default_nettype wire

[tb/tb.sv]
// tb: self-checking testbench for water_refraction_uv_offset (uv offset, thickness, fallback)
// depends on wruv_pkg and the block; a local predictor computes each expected result
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import wruv_pkg::*;

  class refraction_board;
    result_t pending[$];
    int errors = 0;
    int checked = 0;
    int code_seen[4];

    function void note(result_t r);
      pending.push_back(r);
    endfunction

    function void check(result_t got);
      result_t want;
      if (pending.size() == 0) begin
        $display("%0t: result with nothing expected: %h", $realtime, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      checked++;
      code_seen[got.fallback_code]++;
      if (got.out_u !== want.out_u) begin
        $display("%0t: out_u expected %0d actual %0d", $realtime, want.out_u, got.out_u);
        errors++;
      end
      if (got.out_v !== want.out_v) begin
        $display("%0t: out_v expected %0d actual %0d", $realtime, want.out_v, got.out_v);
        errors++;
      end
      if (got.water_thickness !== want.water_thickness) begin
        $display("%0t: water_thickness expected %0d actual %0d", $realtime,
                 want.water_thickness, got.water_thickness);
        errors++;
      end
      if (got.fallback_code !== want.fallback_code) begin
        $display("%0t: fallback_code expected %0d actual %0d", $realtime,
                 want.fallback_code, got.fallback_code);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic busy;
  item_t item = '0;
  logic done;
  result_t result;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  refraction_board board = new();

  // predictor copy of the registers
  longint gain_q12, max_len, bias, limit_reg, margin;

  water_refraction_uv_offset dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) if (!rst && done) board.check(result);

  function automatic longint offset_of(longint nrm, longint t);
    longint p, mag;
    p = nrm * gain_q12 * t;
    mag = p < 0 ? -p : p;
    mag = (mag + (64'sd1 <<< (OFF_SHIFT - 1))) >>> OFF_SHIFT;
    return p < 0 ? -mag : mag;
  endfunction

  function automatic longint ceil_root(longint s);
    longint r;
    r = longint'($sqrt(real'(s)));
    while (r > 0 && (r - 1) * (r - 1) >= s) r--;
    while (r * r < s) r++;
    return r;
  endfunction

  function automatic result_t predict(item_t it);
    result_t r;
    longint u, v, nx, ny, surf, scene, shifted, lim, thick, d, t, ox, oy, sq, len;
    longint cu, cv, m, hi, cap;
    u = it.pixel_u; v = it.pixel_v;
    nx = it.normal_x; ny = it.normal_y;
    surf = it.surface_depth; scene = it.scene_depth; shifted = it.shifted_scene_depth;
    lim = limit_reg == 0 ? 1 : limit_reg;
    thick = scene - surf;
    r.out_u = UV_W'(u > UV_ONE ? UV_ONE : u);
    r.out_v = UV_W'(v > UV_ONE ? UV_ONE : v);
    r.water_thickness = DEPTH_BITS'(thick <= 0 ? 0 : (thick > lim ? lim : thick));
    if (thick <= bias) begin
      r.fallback_code = FB_ZERO;
    end else begin
      d = thick - bias;
      t = d >= lim ? 65536 : (d << 16) / lim;
      ox = offset_of(nx, t);
      oy = offset_of(ny, t);
      sq = ox * ox + oy * oy;
      if (sq > max_len * max_len) begin
        len = ceil_root(sq);
        ox = ox < 0 ? -((-ox) * max_len / len) : ox * max_len / len;
        oy = oy < 0 ? -((-oy) * max_len / len) : oy * max_len / len;
      end
      cu = u + ox; cv = v + oy;
      cap = MARGIN_CAP;
      m = margin > cap ? cap : margin;
      hi = UV_ONE - m;
      if (cu < m || cu > hi || cv < m || cv > hi) r.fallback_code = FB_OFFSCREEN;
      else if (shifted <= surf + bias) r.fallback_code = FB_FOREGROUND;
      else begin
        r.fallback_code = FB_NONE;
        r.out_u = UV_W'(cu);
        r.out_v = UV_W'(cv);
      end
    end
    return r;
  endfunction

  // leaves cfg_valid high; setup drops it after the last write
  task automatic write_reg(cfg_reg_t idx, logic [CFG_W-1:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_STRENGTH:   gain_q12 = longint'($signed(val[15:0]));
      REG_MAX_OFFSET: max_len = val[15:0];
      REG_BIAS:       bias = val;
      REG_LIMIT:      limit_reg = val;
      REG_MARGIN:     margin = val[14:0];
      default: ;
    endcase
  endtask

  task automatic setup(logic [15:0] g, logic [15:0] mx, logic [31:0] b, logic [31:0] l,
                       logic [14:0] mg);
    write_reg(REG_STRENGTH, {16'h0, g});
    write_reg(REG_MAX_OFFSET, {16'h0, mx});
    write_reg(REG_BIAS, b);
    write_reg(REG_LIMIT, l);
    write_reg(REG_MARGIN, {17'h0, mg});
    cfg_valid <= 0;
  endtask

  // leaves start high so beats can follow back to back; drain drops it
  task automatic send(item_t it, bit gaps);
    int wait_n;
    wait_n = gaps && $urandom_range(0, 3) != 0 ? $urandom_range(0, 15) : 0;
    if (wait_n > 0) begin
      start <= 0;
      repeat (wait_n) @(posedge clk);
    end
    start <= 1;
    item <= it;
    do @(posedge clk); while (busy);
    board.note(predict(it));
  endtask

  task automatic drain();
    start <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (70) @(posedge clk);
  endtask

  function automatic item_t rand_item();
    item_t it;
    longint surf, th;
    it.pixel_u = UV_W'($urandom_range(0, 9) == 0 ? $urandom_range(0, 131071)
                                                  : $urandom_range(0, 65536));
    it.pixel_v = UV_W'($urandom_range(0, 9) == 0 ? $urandom_range(0, 131071)
                                                  : $urandom_range(0, 65536));
    it.normal_x = 16'($urandom);
    it.normal_y = 16'($urandom);
    if ($urandom_range(0, 3) == 0) begin
      it.surface_depth = $urandom;
      it.scene_depth = $urandom;
      it.shifted_scene_depth = $urandom;
    end else begin
      // plausible water: opaque behind surface by a modest amount
      surf = $urandom_range(0, 32'h4000_0000);
      th = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 262144);
      it.surface_depth = DEPTH_BITS'(surf);
      it.scene_depth = DEPTH_BITS'(surf + th);
      it.shifted_scene_depth = DEPTH_BITS'(surf + $urandom_range(0, 400000));
    end
    return it;
  endfunction

  initial begin
    item_t it;
    bit burst;
    gain_q12 = 4096; max_len = 2048; bias = 0; limit_reg = 65536; margin = 0;
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: reset settings
    it = '{32768, 32768, 16384, -16384, 65536, 131072, 200000};
    send(it, 0);
    it = '{0, 65536, 32767, -32768, 100, 50, 0};             // negative thickness
    send(it, 0);
    it = '{131071, 131071, 0, 0, 0, 0, 0};                   // uv beyond one
    send(it, 0);
    it = '{0, 0, -32768, -32768, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF}; // off screen
    send(it, 0);
    it = '{40000, 40000, 1000, 1000, 65536, 200000, 65536};  // foreground
    send(it, 0);
    it = '{65536, 65536, 32767, 32767, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
    send(it, 0);
    drain();
    setup(16'h8000, 16'hFFFF, 32'hFFFF_FFFF, 32'h0, 15'h7FFF);   // zero limit, max margin
    it = '{32768, 32768, 16384, 16384, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
    send(it, 0);
    it = '{32768, 32768, 16384, 16384, 0, 32'hFFFF_FFFE, 32'hFFFF_FFFF};
    send(it, 0);
    drain();
    setup(16'h7FFF, 16'h0, 32'h0, 32'hFFFF_FFFF, 15'h0);
    for (int k = 0; k < 4; k++) send(rand_item(), 0);
    drain();

    // random phases over several register settings
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: setup(16'd4096, 16'd2048, 32'd0, 32'd65536, 15'd0);
        1: setup(16'h8000, 16'hFFFF, 32'd1000, 32'd1, 15'd32702);
        2: setup(16'h7FFF, 16'd300, 32'd0, 32'hFFFF_FFFF, 15'd100);
        default: setup(16'($urandom), 16'($urandom), 32'($urandom_range(0, 100000)),
                       32'($urandom_range(0, 3) == 0 ? $urandom
                                                     : $urandom_range(0, 300000)),
                       15'($urandom_range(0, 4000)));
      endcase
      for (int k = 0; k < 100; k++) begin
        burst = (k / 25) % 2;
        send(rand_item(), !burst);
      end
      drain();
    end

    $display("ran %0d pixel results over 10 register settings; codes none/zero/off/fg: %0d %0d %0d %0d",
             board.checked, board.code_seen[0], board.code_seen[1], board.code_seen[2],
             board.code_seen[3]);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("FAILED: results differ");
    $finish;
  end
endmodule
`default_nettype wire

[files.f]
hdl/wruv_pkg.sv
hdl/wruv_div.sv
hdl/wruv_sqrt.sv
hdl/water_refraction_uv_offset.sv
tb/tb.sv
